### rtl/core/growable_slot_pool_allocator_assert.svh
// Assertion macros shared by the checkers of the slot pool allocator.
// Depends on nothing; include it by its bare file name.
`ifndef GROWABLE_SLOT_POOL_ALLOCATOR_ASSERT_SVH
`define GROWABLE_SLOT_POOL_ALLOCATOR_ASSERT_SVH

// Consequent must hold in the same cycle as the antecedent.
`define GSPA_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("slot pool check failed in the same cycle");

// Consequent must hold in the cycle after the antecedent.
`define GSPA_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("slot pool check failed in the next cycle");

`endif

### rtl/core/gspa_pkg.sv
// Package of the slot pool allocator: field widths, codes and transfer structs.
// Depends on nothing; gspa_alu, the top level, the checker and the testbench import it.
package gspa_pkg;

  // Field and datapath widths.
  localparam int unsigned OP_W      = 2;
  localparam int unsigned SLOT_W    = 10;
  localparam int unsigned CW        = 11;
  localparam int unsigned RULE_W    = 12;
  localparam int unsigned STATUS_W  = 3;
  localparam int unsigned ALU_W     = 12;
  localparam int unsigned CFG_IDX_W = 2;

  // Operation codes.
  localparam logic [OP_W-1:0] OP_ALLOC  = 2'd0;
  localparam logic [OP_W-1:0] OP_FREE   = 2'd1;
  localparam logic [OP_W-1:0] OP_REWIND = 2'd2;
  localparam logic [OP_W-1:0] OP_INIT   = 2'd3;

  // Status codes.
  localparam logic [STATUS_W-1:0] STS_OK      = 3'd0;
  localparam logic [STATUS_W-1:0] STS_EXHAUST = 3'd1;
  localparam logic [STATUS_W-1:0] STS_NOFREE  = 3'd2;
  localparam logic [STATUS_W-1:0] STS_NOINIT  = 3'd3;
  localparam logic [STATUS_W-1:0] STS_BADCFG  = 3'd4;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_CAP = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_CAP  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_GROWTH   = 2'd2;

  // Input transfer.
  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
  } in_item_t;

  // Result transfer.
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [SLOT_W-1:0]   granted_slot;
    logic [CW-1:0]       in_use;
    logic [CW-1:0]       grown_capacity;
    logic [CW-1:0]       reclaimed;
  } out_item_t;

endpackage

### rtl/core/gspa_ram.sv
// Simple dual-port memory with a registered read, used for the link and pool tables.
// Depends on nothing; contents are undefined until written.
module gspa_ram #(
  parameter int unsigned DEPTH = 16,
  parameter int unsigned WIDTH = 11,
  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write and one registered read per cycle.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

### rtl/core/gspa_alu.sv
// Shared add/subtract and compare unit of the slot pool allocator.
// Depends on gspa_pkg for the datapath width.
module gspa_alu
  import gspa_pkg::*;
(
  input  logic [ALU_W-1:0] a,
  input  logic [ALU_W-1:0] b,
  input  logic             sub,
  output logic [ALU_W-1:0] res,
  output logic             lt,
  output logic             eq
);

  // Sum or difference, plus an unsigned ordering of the operands.
  assign res = sub ? (a - b) : (a + b);
  assign lt  = a < b;
  assign eq  = a == b;

endmodule

### rtl/core/growable_slot_pool_allocator.sv
// Top level of the growable slot pool allocator: sequencer, state and config registers.
// Depends on gspa_pkg, gspa_alu and gspa_ram.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------
//   input    | start high, busy low   | in_item  (op, slot)
//   result   | out_strobe, one cycle  | out_item (status .. reclaimed)
//   config   | cfg_we                 | cfg_index, cfg_wdata
//
// Every operation steps through one shared add/compare unit under a sequencer. An op
// refused at the start (no init, nothing to free) shows its result in the next cycle;
// an alloc that grows a new pool first passes the check, growth, grant and count states.
// The fold state repeats for each subtraction of MAX_SLOTS needed to bring a slot in range.
// Reset is synchronous and clears all control state; the tables need no clearing
// pass. The result strobe cannot be stalled; busy stays high until it has shown.
module growable_slot_pool_allocator
  import gspa_pkg::*;
#(
  parameter int unsigned MAX_SLOTS = 1024,
  parameter int unsigned MAX_POOLS = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  in_item_t             in_item,
  output logic                 out_strobe,
  output out_item_t            out_item,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [RULE_W-1:0]    cfg_wdata
);

  localparam int unsigned LAW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int unsigned PIW = (MAX_POOLS > 1) ? $clog2(MAX_POOLS) : 1;
  localparam int unsigned PCW = $clog2(MAX_POOLS + 1);
  localparam logic [CW-1:0]    CAP_LIM    = CW'((MAX_SLOTS > 2047) ? 2047 : MAX_SLOTS);
  localparam logic [ALU_W-1:0] MOD_B      = ALU_W'((MAX_SLOTS > 2048) ? 2048 : MAX_SLOTS);
  localparam logic [PCW-1:0]   POOLS_FULL = PCW'(MAX_POOLS);

  typedef enum logic [18:0] {
    S_IDLE     = 19'h00001,
    S_INIT_CHK = 19'h00002,
    S_RW_RD    = 19'h00004,
    S_RW_SET   = 19'h00008,
    S_FR_MOD   = 19'h00010,
    S_FR_WR    = 19'h00020,
    S_AL_CHK   = 19'h00040,
    S_EX_CAP   = 19'h00080,
    S_EX_ADV   = 19'h00100,
    S_EX_LIM   = 19'h00200,
    S_EX_ROOM  = 19'h00400,
    S_EX_CLAMP = 19'h00800,
    S_EX_NEW   = 19'h01000,
    S_AL_HW    = 19'h02000,
    S_AL_BUMP  = 19'h04000,
    S_AL_MOD   = 19'h08000,
    S_AL_LINK  = 19'h10000,
    S_AL_INC   = 19'h20000,
    S_DONE     = 19'h40000
  } state_t;

  // Configuration registers.
  logic [CW-1:0]     init_cap_r, max_cap_r;
  logic [RULE_W-1:0] rule_r;

  // Allocator state.
  state_t            state_r, state_nxt;
  logic [CW-1:0]     in_use_r, in_use_nxt;
  logic [CW-1:0]     high_water_r, high_water_nxt;
  logic [CW-1:0]     reachable_r, reachable_nxt;
  logic [CW-1:0]     head_r, head_nxt;
  logic [PCW-1:0]    pool_count_r, pool_count_nxt;
  logic [PIW-1:0]    active_r, active_nxt;

  // Per-item working and result registers.
  logic [CW-1:0]       mod_r, mod_nxt;
  logic [CW-1:0]       diff_r, diff_nxt;
  logic [CW-1:0]       room_r, room_nxt;
  logic                bump_r, bump_nxt;
  logic [STATUS_W-1:0] status_r, status_nxt;
  logic [SLOT_W-1:0]   granted_r, granted_nxt;
  logic [CW-1:0]       recl_r, recl_nxt;

  // Shared unit and table ports.
  logic [ALU_W-1:0] alu_a, alu_b, alu_res;
  logic             alu_sub, alu_lt, alu_eq;
  logic             pool_we;
  logic [PIW-1:0]   pool_waddr, pool_raddr;
  logic [CW-1:0]    pool_wdata, pool_rdata;
  logic             link_we;
  logic [CW-1:0]    link_rdata;

  // Derived configuration values.
  logic [CW-1:0]  cap_w, lim_w;
  logic           rule_zero, rule_dbl, rule_lim, advance;
  logic [PCW-1:0] next_pool;

  assign cap_w     = (max_cap_r < CAP_LIM) ? max_cap_r : CAP_LIM;
  assign rule_zero = rule_r == '0;
  assign rule_dbl  = &rule_r;
  assign rule_lim  = rule_r[RULE_W-1] && !rule_dbl;
  assign lim_w     = ~rule_r[CW-1:0];
  assign next_pool = PCW'(active_r) + PCW'(1);
  assign advance   = next_pool != pool_count_r;

  gspa_alu u_alu (
    .a   (alu_a),
    .b   (alu_b),
    .sub (alu_sub),
    .res (alu_res),
    .lt  (alu_lt),
    .eq  (alu_eq)
  );

  gspa_ram #(.DEPTH(MAX_POOLS), .WIDTH(CW)) u_pool_ram (
    .clk   (clk),
    .we    (pool_we),
    .waddr (pool_waddr),
    .wdata (pool_wdata),
    .raddr (pool_raddr),
    .rdata (pool_rdata)
  );

  gspa_ram #(.DEPTH(MAX_SLOTS), .WIDTH(CW)) u_link_ram (
    .clk   (clk),
    .we    (link_we),
    .waddr (LAW'(mod_r)),
    .wdata (head_r),
    .raddr (LAW'(mod_r)),
    .rdata (link_rdata)
  );

  // Sequencer: each working state drives the shared unit at most once and updates the state.
  always_comb begin
    state_nxt      = state_r;
    in_use_nxt     = in_use_r;
    high_water_nxt = high_water_r;
    reachable_nxt  = reachable_r;
    head_nxt       = head_r;
    pool_count_nxt = pool_count_r;
    active_nxt     = active_r;
    mod_nxt        = mod_r;
    diff_nxt       = diff_r;
    room_nxt       = room_r;
    bump_nxt       = bump_r;
    status_nxt     = status_r;
    granted_nxt    = granted_r;
    recl_nxt       = recl_r;
    alu_a          = '0;
    alu_b          = '0;
    alu_sub        = 1'b1;
    pool_we        = 1'b0;
    pool_waddr     = PIW'(pool_count_r);
    pool_wdata     = diff_r;
    pool_raddr     = PIW'(next_pool);
    link_we        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (start) begin
          status_nxt  = STS_OK;
          granted_nxt = '0;
          recl_nxt    = '0;
          bump_nxt    = 1'b0;
          mod_nxt     = CW'(in_item.slot);
          if (in_item.op == OP_INIT) begin
            state_nxt = S_INIT_CHK;
          end else if (pool_count_r == '0) begin
            status_nxt = STS_NOINIT;
            state_nxt  = S_DONE;
          end else if (in_item.op == OP_REWIND) begin
            state_nxt = S_RW_RD;
          end else if (in_item.op == OP_FREE) begin
            if (in_use_r == '0) begin
              status_nxt = STS_NOFREE;
              state_nxt  = S_DONE;
            end else begin
              state_nxt = S_FR_MOD;
            end
          end else begin
            state_nxt = S_AL_CHK;
          end
        end
      end
      // Init: the first pool must be nonzero and fit the effective capacity.
      S_INIT_CHK: begin
        alu_a = ALU_W'(cap_w);
        alu_b = ALU_W'(init_cap_r);
        if (init_cap_r == '0 || alu_lt) begin
          status_nxt = STS_BADCFG;
        end else begin
          pool_we        = 1'b1;
          pool_waddr     = '0;
          pool_wdata     = init_cap_r;
          pool_count_nxt = PCW'(1);
          active_nxt     = '0;
          reachable_nxt  = init_cap_r;
          head_nxt       = '0;
          in_use_nxt     = '0;
          high_water_nxt = '0;
        end
        state_nxt = S_DONE;
      end
      // Rewind: fetch the first pool size, then forget all allocations.
      S_RW_RD: begin
        pool_raddr = '0;
        state_nxt  = S_RW_SET;
      end
      S_RW_SET: begin
        recl_nxt       = in_use_r;
        in_use_nxt     = '0;
        high_water_nxt = '0;
        head_nxt       = '0;
        active_nxt     = '0;
        reachable_nxt  = pool_rdata;
        state_nxt      = S_DONE;
      end
      // Free: fold the slot into range, then push it onto the free list.
      S_FR_MOD: begin
        alu_a = ALU_W'(mod_r);
        alu_b = MOD_B;
        if (!alu_lt) begin
          mod_nxt = CW'(alu_res);
        end else begin
          state_nxt = S_FR_WR;
        end
      end
      S_FR_WR: begin
        link_we    = 1'b1;
        head_nxt   = mod_r;
        alu_a      = ALU_W'(in_use_r);
        alu_b      = ALU_W'(1);
        in_use_nxt = CW'(alu_res);
        state_nxt  = S_DONE;
      end
      // Alloc: compare the slots in use against the reachable slots.
      S_AL_CHK: begin
        alu_a = ALU_W'(in_use_r);
        alu_b = ALU_W'(reachable_r);
        if (alu_eq) begin
          state_nxt = S_EX_CAP;
        end else if (alu_lt) begin
          state_nxt = S_AL_HW;
        end else begin
          status_nxt = STS_EXHAUST;
          state_nxt  = S_DONE;
        end
      end
      // Growth is off or the capacity is used up; else reuse or grow a pool.
      S_EX_CAP: begin
        alu_a = ALU_W'(reachable_r);
        alu_b = ALU_W'(cap_w);
        if (rule_zero || !alu_lt) begin
          status_nxt = STS_EXHAUST;
          state_nxt  = S_DONE;
        end else if (advance) begin
          state_nxt = S_EX_ADV;
        end else begin
          state_nxt = S_EX_LIM;
        end
      end
      // Move into the next pool that already exists.
      S_EX_ADV: begin
        alu_a         = ALU_W'(reachable_r);
        alu_b         = ALU_W'(pool_rdata);
        alu_sub       = 1'b0;
        reachable_nxt = CW'(alu_res);
        head_nxt      = reachable_r;
        active_nxt    = PIW'(next_pool);
        state_nxt     = S_AL_HW;
      end
      // Size of a new pool from the growth rule.
      S_EX_LIM: begin
        alu_a = ALU_W'(reachable_r);
        alu_b = ALU_W'(lim_w);
        if (rule_lim) begin
          diff_nxt = alu_lt ? reachable_r : lim_w;
        end else if (rule_dbl) begin
          diff_nxt = reachable_r;
        end else begin
          diff_nxt = rule_r[CW-1:0];
        end
        state_nxt = S_EX_ROOM;
      end
      S_EX_ROOM: begin
        alu_a     = ALU_W'(cap_w);
        alu_b     = ALU_W'(reachable_r);
        room_nxt  = CW'(alu_res);
        state_nxt = S_EX_CLAMP;
      end
      // Clamp the new pool so the total stays within the capacity.
      S_EX_CLAMP: begin
        alu_a = ALU_W'(diff_r);
        alu_b = ALU_W'(room_r);
        if (!alu_lt && !alu_eq) begin
          diff_nxt = room_r;
        end
        state_nxt = S_EX_NEW;
      end
      S_EX_NEW: begin
        alu_a   = ALU_W'(reachable_r);
        alu_b   = ALU_W'(diff_r);
        alu_sub = 1'b0;
        if (diff_r == '0 || pool_count_r == POOLS_FULL) begin
          status_nxt = STS_EXHAUST;
          state_nxt  = S_DONE;
        end else begin
          pool_we        = 1'b1;
          active_nxt     = PIW'(pool_count_r);
          pool_count_nxt = pool_count_r + PCW'(1);
          head_nxt       = reachable_r;
          reachable_nxt  = CW'(alu_res);
          state_nxt      = S_AL_HW;
        end
      end
      // Grant the head; take the next slot from the mark or from the free list.
      S_AL_HW: begin
        granted_nxt = head_r[SLOT_W-1:0];
        alu_a       = ALU_W'(in_use_r);
        alu_b       = ALU_W'(high_water_r);
        if (alu_eq) begin
          bump_nxt  = 1'b1;
          state_nxt = S_AL_BUMP;
        end else begin
          mod_nxt   = head_r;
          state_nxt = S_AL_MOD;
        end
      end
      S_AL_BUMP: begin
        alu_a     = ALU_W'(head_r);
        alu_b     = ALU_W'(1);
        alu_sub   = 1'b0;
        head_nxt  = CW'(alu_res);
        state_nxt = S_AL_INC;
      end
      S_AL_MOD: begin
        alu_a = ALU_W'(mod_r);
        alu_b = MOD_B;
        if (!alu_lt) begin
          mod_nxt = CW'(alu_res);
        end else begin
          state_nxt = S_AL_LINK;
        end
      end
      S_AL_LINK: begin
        head_nxt  = link_rdata;
        state_nxt = S_AL_INC;
      end
      S_AL_INC: begin
        alu_a      = ALU_W'(in_use_r);
        alu_b      = ALU_W'(1);
        alu_sub    = 1'b0;
        in_use_nxt = CW'(alu_res);
        if (bump_r) begin
          high_water_nxt = CW'(alu_res);
        end
        state_nxt = S_DONE;
      end
      S_DONE: begin
        state_nxt = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Control state and allocator registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      in_use_r     <= '0;
      high_water_r <= '0;
      reachable_r  <= '0;
      head_r       <= '0;
      pool_count_r <= '0;
      active_r     <= '0;
    end else begin
      state_r      <= state_nxt;
      in_use_r     <= in_use_nxt;
      high_water_r <= high_water_nxt;
      reachable_r  <= reachable_nxt;
      head_r       <= head_nxt;
      pool_count_r <= pool_count_nxt;
      active_r     <= active_nxt;
    end
  end

  // Working and result registers need no reset.
  always_ff @(posedge clk) begin
    mod_r     <= mod_nxt;
    diff_r    <= diff_nxt;
    room_r    <= room_nxt;
    bump_r    <= bump_nxt;
    status_r  <= status_nxt;
    granted_r <= granted_nxt;
    recl_r    <= recl_nxt;
  end

  // Configuration writes; an index beyond the list is ignored.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      init_cap_r <= CW'(16);
      max_cap_r  <= CW'(1024);
      rule_r     <= '1;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_INIT_CAP: init_cap_r <= cfg_wdata[CW-1:0];
        CFG_MAX_CAP:  max_cap_r  <= cfg_wdata[CW-1:0];
        CFG_GROWTH:   rule_r     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  // Result transfer.
  assign busy       = state_r != S_IDLE;
  assign out_strobe = state_r == S_DONE;

  always_comb begin
    out_item.status         = status_r;
    out_item.granted_slot   = granted_r;
    out_item.in_use         = in_use_r;
    out_item.grown_capacity = reachable_r;
    out_item.reclaimed      = recl_r;
  end

endmodule

### rtl/core/gspa_check.sv
// Port-level checker of the slot pool allocator, bound to the top level.
// Depends on gspa_pkg and growable_slot_pool_allocator_assert.svh.
`include "growable_slot_pool_allocator_assert.svh"

module gspa_check
  import gspa_pkg::*;
(
  input logic      clk,
  input logic      rst_n,
  input logic      start,
  input logic      busy,
  input logic      out_strobe,
  input out_item_t out_item
);

  // An accepted item keeps the block busy until its result has shown.
  `GSPA_ASSERT_NEXT(a_busy_after_start, clk, rst_n, start && !busy, busy)

  // A result is a single-cycle pulse and the block is free right after it.
  `GSPA_ASSERT_NEXT(a_idle_after_result, clk, rst_n, out_strobe, !out_strobe && !busy)

  // A result only shows while an item is being worked on.
  `GSPA_ASSERT_NOW(a_strobe_busy, clk, rst_n, out_strobe, busy)

  // A failed operation grants no slot.
  `GSPA_ASSERT_NOW(a_grant_on_ok, clk, rst_n,
    out_strobe && out_item.status != STS_OK, out_item.granted_slot == '0)

  // Slots are reclaimed only by a successful operation.
  `GSPA_ASSERT_NOW(a_reclaim_on_ok, clk, rst_n,
    out_strobe && out_item.reclaimed != '0, out_item.status == STS_OK)

endmodule

bind growable_slot_pool_allocator gspa_check u_gspa_check (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);

### tb/sv/tb_growable_slot_pool_allocator.sv
// Self-checking testbench for the growable slot pool allocator: directed and random
// operations across several register settings, each result checked against a model.
// Depends on gspa_pkg and the growable_slot_pool_allocator RTL.
`timescale 1ns / 100ps

module tb_growable_slot_pool_allocator;
  import gspa_pkg::*;

  localparam int unsigned MAX_SLOTS      = 1024;
  localparam int unsigned MAX_POOLS      = 16;
  localparam int unsigned WATCHDOG_LIMIT = 5000;
  localparam int unsigned PHASES         = 14;
  localparam int unsigned PHASE_OPS      = 75;

  // Allocator state as the model tracks it.
  typedef struct {
    int unsigned in_use;
    int unsigned high_water;
    int unsigned reachable;
    int unsigned head;
    int unsigned pool_cnt;
    int unsigned active;
    int unsigned link[MAX_SLOTS];
    int unsigned pool_size[MAX_POOLS];
  } pool_state_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              start = 1'b0;
  logic              busy;
  in_item_t          in_item = '0;
  logic              out_strobe;
  out_item_t         out_item;
  logic              cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [RULE_W-1:0] cfg_wdata = '0;

  // Register values as last written.
  int unsigned       cfg_init_cap = 16;
  int unsigned       cfg_max_cap = 1024;
  logic [RULE_W-1:0] cfg_rule = 12'hFFF;

  // Two model copies: one follows the ops as they are planned, one as they transfer.
  pool_state_t plan_pool;
  pool_state_t issued_pool;
  int          held_slots[$];
  in_item_t    ops_to_issue[$];
  out_item_t   replies_due[$];
  out_item_t   reply_want;
  int unsigned ops_issued = 0;
  int unsigned idle_cycles = 0;
  int unsigned error_count = 0;

  growable_slot_pool_allocator #(
    .MAX_SLOTS(MAX_SLOTS),
    .MAX_POOLS(MAX_POOLS)
  ) dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_strobe(out_strobe),
    .out_item  (out_item),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic void clear_pool(ref pool_state_t st);
    st.in_use = 0;
    st.high_water = 0;
    st.reachable = 0;
    st.head = 0;
    st.pool_cnt = 0;
    st.active = 0;
    foreach (st.link[i]) st.link[i] = 0;
    foreach (st.pool_size[i]) st.pool_size[i] = 0;
  endfunction

  // Make room once every reachable slot is taken: step into the next existing pool,
  // or create a new one sized by the growth rule. Returns 0 when nothing can be done.
  function automatic bit grow_or_advance(ref pool_state_t st);
    int          g;
    int unsigned cap;
    int unsigned diff;
    int unsigned lim;
    g = $signed(cfg_rule);
    cap = (cfg_max_cap < MAX_SLOTS) ? cfg_max_cap : MAX_SLOTS;
    if (g == 0 || st.reachable >= cap) return 1'b0;
    if (st.active + 1 < st.pool_cnt) begin
      st.active++;
      st.head = st.reachable;
      st.reachable += st.pool_size[st.active % MAX_POOLS];
      return 1'b1;
    end
    if (g < -1) begin
      lim = -g - 1;
      diff = (st.reachable <= lim) ? st.reachable : lim;
    end else if (g == -1) begin
      diff = st.reachable;
    end else begin
      diff = g;
    end
    if (st.reachable + diff > cap) diff = cap - st.reachable;
    if (diff == 0 || st.pool_cnt >= MAX_POOLS) return 1'b0;
    st.pool_size[st.pool_cnt] = diff;
    st.active = st.pool_cnt;
    st.pool_cnt++;
    st.head = st.reachable;
    st.reachable += diff;
    return 1'b1;
  endfunction

  // Apply one operation to a model copy and return the result it must produce.
  function automatic out_item_t pool_op_result(ref pool_state_t st, input in_item_t it);
    out_item_t   r;
    int unsigned cap;
    int unsigned granted;
    r = '0;
    granted = 0;
    cap = (cfg_max_cap < MAX_SLOTS) ? cfg_max_cap : MAX_SLOTS;
    if (it.op == OP_INIT) begin
      if (cfg_init_cap == 0 || cfg_init_cap > cap) begin
        r.status = STS_BADCFG;
      end else begin
        st.pool_size[0] = cfg_init_cap;
        st.pool_cnt = 1;
        st.active = 0;
        st.reachable = cfg_init_cap;
        st.head = 0;
        st.in_use = 0;
        st.high_water = 0;
      end
    end else if (st.pool_cnt == 0) begin
      r.status = STS_NOINIT;
    end else if (it.op == OP_REWIND) begin
      r.reclaimed = CW'(st.in_use);
      st.in_use = 0;
      st.high_water = 0;
      st.head = 0;
      st.active = 0;
      st.reachable = st.pool_size[0];
    end else if (it.op == OP_FREE) begin
      if (st.in_use == 0) begin
        r.status = STS_NOFREE;
      end else begin
        st.in_use--;
        st.link[it.slot % MAX_SLOTS] = st.head;
        st.head = it.slot;
      end
    end else begin
      if (st.in_use > st.reachable ||
          (st.in_use == st.reachable && !grow_or_advance(st))) begin
        r.status = STS_EXHAUST;
      end else begin
        granted = st.head;
        if (st.in_use == st.high_water) begin
          st.head = (st.head + 1) & 32'h7FF;
          st.high_water++;
        end else begin
          st.head = st.link[st.head % MAX_SLOTS];
        end
        st.in_use++;
      end
    end
    r.granted_slot = SLOT_W'(granted);
    r.in_use = CW'(st.in_use);
    r.grown_capacity = CW'(st.reachable);
    return r;
  endfunction

  // Driver: present the next planned op once the previous one has transferred.
  always @(posedge clk) begin
    if (!rst_n) begin
      start <= 1'b0;
      in_item <= '0;
    end else begin
      if (start && !busy) begin
        replies_due.push_back(pool_op_result(issued_pool, in_item));
        ops_issued++;
      end
      if (!start || !busy) begin
        if (ops_to_issue.size() != 0 &&
            !((ops_issued < 300 || ops_issued > 550) && $urandom_range(0, 99) < 13)) begin
          in_item <= ops_to_issue.pop_front();
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: every strobed result must match the oldest outstanding one.
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      if (replies_due.size() == 0) begin
        $error("result strobed with nothing outstanding");
        error_count++;
      end else begin
        reply_want = replies_due.pop_front();
        if (out_item.status !== reply_want.status) begin
          $error("status: expected %0d, got %0d", reply_want.status, out_item.status);
          error_count++;
        end
        if (out_item.granted_slot !== reply_want.granted_slot) begin
          $error("granted_slot: expected %0d, got %0d",
                 reply_want.granted_slot, out_item.granted_slot);
          error_count++;
        end
        if (out_item.in_use !== reply_want.in_use) begin
          $error("in_use: expected %0d, got %0d", reply_want.in_use, out_item.in_use);
          error_count++;
        end
        if (out_item.grown_capacity !== reply_want.grown_capacity) begin
          $error("grown_capacity: expected %0d, got %0d",
                 reply_want.grown_capacity, out_item.grown_capacity);
          error_count++;
        end
        if (out_item.reclaimed !== reply_want.reclaimed) begin
          $error("reclaimed: expected %0d, got %0d", reply_want.reclaimed, out_item.reclaimed);
          error_count++;
        end
      end
    end
  end

  // Watchdog: too long without any transfer on either side ends the run.
  always @(posedge clk) begin
    if (rst_n) begin
      if ((start && !busy) || out_strobe) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Queue one op and track which slots the client holds, so frees can target them.
  task automatic queue_op(input logic [OP_W-1:0] op, input int unsigned slot);
    in_item_t  it;
    out_item_t r;
    it.op = op;
    it.slot = SLOT_W'(slot);
    r = pool_op_result(plan_pool, it);
    ops_to_issue.push_back(it);
    if (r.status == STS_OK) begin
      if (op == OP_ALLOC) begin
        held_slots.push_back(r.granted_slot);
      end else if (op == OP_FREE) begin
        foreach (held_slots[i]) begin
          if (held_slots[i] == slot) begin
            held_slots.delete(i);
            break;
          end
        end
      end else begin
        held_slots.delete();
      end
    end
  endtask

  // Wait until every queued op has transferred and every result has come back.
  task automatic wait_for_quiet();
    do @(posedge clk);
    while (ops_to_issue.size() != 0 || start || busy || replies_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  // Registers change only while the block is quiet.
  task automatic set_regs(input int unsigned init_cap, input int unsigned max_cap,
                          input int rule);
    wait_for_quiet();
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= CFG_INIT_CAP;
    cfg_wdata <= RULE_W'(init_cap);
    @(posedge clk);
    cfg_index <= CFG_MAX_CAP;
    cfg_wdata <= RULE_W'(max_cap);
    @(posedge clk);
    cfg_index <= CFG_GROWTH;
    cfg_wdata <= RULE_W'(rule);
    @(posedge clk);
    cfg_we <= 1'b0;
    cfg_init_cap = init_cap;
    cfg_max_cap = max_cap;
    cfg_rule = RULE_W'(rule);
  endtask

  initial begin
    int unsigned init_cap;
    int unsigned max_cap;
    int          rule;
    int unsigned alloc_pct;
    int unsigned r;
    clear_pool(plan_pool);
    clear_pool(issued_pool);
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;

    // Directed: ops before any init, unchecked frees, free-list reuse, rewind.
    queue_op(OP_ALLOC, 0);
    queue_op(OP_FREE, 1023);
    queue_op(OP_REWIND, 0);
    queue_op(OP_INIT, 0);
    queue_op(OP_FREE, 5);
    queue_op(OP_ALLOC, 0);
    queue_op(OP_ALLOC, 0);
    queue_op(OP_FREE, 0);
    queue_op(OP_FREE, 1023);
    queue_op(OP_ALLOC, 0);
    queue_op(OP_ALLOC, 0);
    queue_op(OP_ALLOC, 0);
    queue_op(OP_REWIND, 0);

    // A zero initial capacity is a bad setting.
    set_regs(0, 1024, -1);
    queue_op(OP_INIT, 0);

    // No growth allowed: the third alloc is refused.
    set_regs(2, 3, 0);
    queue_op(OP_INIT, 0);
    repeat (3) queue_op(OP_ALLOC, 0);

    // Large fixed step clamped to the bound, then rewind and walk back into that pool.
    set_regs(2, 3, 1024);
    queue_op(OP_INIT, 0);
    repeat (4) queue_op(OP_ALLOC, 0);
    queue_op(OP_REWIND, 0);
    repeat (3) queue_op(OP_ALLOC, 0);

    // Random phases, the first few pinned to extreme settings.
    for (int p = 0; p < PHASES; p++) begin
      case (p)
        0: begin init_cap = 1;    max_cap = 1024; rule = 1;     end
        1: begin init_cap = 1024; max_cap = 1024; rule = -1;    end
        2: begin init_cap = 1;    max_cap = 1;    rule = 0;     end
        3: begin init_cap = 4;    max_cap = 3;    rule = -2;    end
        4: begin init_cap = 1;    max_cap = 64;   rule = -1025; end
        5: begin init_cap = 3;    max_cap = 1024; rule = 1024;  end
        default: begin
          init_cap = ($urandom_range(0, 9) == 0) ? $urandom_range(1, 1024)
                                                 : $urandom_range(1, 24);
          case ($urandom_range(0, 3))
            0: max_cap = 1024;
            1: max_cap = $urandom_range(1, 1024);
            default: max_cap = $urandom_range(1, 96);
          endcase
          case ($urandom_range(0, 6))
            0: rule = 0;
            1: rule = -1;
            2: rule = $urandom_range(1, 8);
            3: rule = -int'($urandom_range(2, 12));
            4: rule = ($urandom_range(0, 1) != 0) ? 1024 : -1025;
            default: rule = int'($urandom_range(0, 2049)) - 1025;
          endcase
        end
      endcase
      set_regs(init_cap, max_cap, rule);
      case ($urandom_range(0, 2))
        0: alloc_pct = 45;
        1: alloc_pct = 60;
        default: alloc_pct = 75;
      endcase
      if ($urandom_range(0, 9) != 0) queue_op(OP_INIT, 0);
      else queue_op(OP_REWIND, 0);
      // Mostly allocs and frees of held slots; some stray frees, rewinds and inits.
      for (int k = 1; k < PHASE_OPS; k++) begin
        r = $urandom_range(0, 99);
        if (r < alloc_pct) begin
          queue_op(OP_ALLOC, $urandom_range(0, 1023));
        end else if (r < 88 && held_slots.size() != 0) begin
          queue_op(OP_FREE, held_slots[$urandom_range(0, held_slots.size() - 1)]);
        end else if (r < 95) begin
          queue_op(OP_FREE, $urandom_range(0, 1023));
        end else if (r < 98) begin
          queue_op(OP_REWIND, $urandom_range(0, 1023));
        end else begin
          queue_op(OP_INIT, $urandom_range(0, 1023));
        end
      end
    end

    wait_for_quiet();
    repeat (20) @(posedge clk);
    if (replies_due.size() != 0) begin
      $error("%0d results never arrived", replies_due.size());
      error_count++;
    end
    if (error_count == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule
